### sv/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg
// Shared types, constants and the sequencer program for the divisor-pair
// enumerator.
// ----------------------------------------------------------------------------
package pdp_pkg;

  // result field widths
  localparam int SMALL_W = 8;
  localparam int LARGE_W = 14;

  // first trial divisor
  localparam logic [SMALL_W-1:0] FIRST_CAND = SMALL_W'(2);

  // program step addresses
  typedef logic [2:0] step_t;
  localparam step_t STEP_WAIT  = 3'd0;
  localparam step_t STEP_CHKIN = 3'd1;
  localparam step_t STEP_TEST  = 3'd2;
  localparam step_t STEP_DIV   = 3'd3;
  localparam step_t STEP_CHK   = 3'd4;
  localparam step_t STEP_FIN   = 3'd5;
  localparam step_t STEP_ERR   = 3'd6;

  // what a step writes into the result register
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PAIR,
    EMIT_FINAL,
    EMIT_ERROR
  } emit_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_BAD,
    COND_SQ_GT,
    COND_DIV_LAST
  } cond_t;

  // one control word
  typedef struct packed {
    logic  in_ready;
    logic  div_load;
    logic  div_step;
    logic  check;
    emit_t emit;
    cond_t cond;
    logic  stay;
    step_t target;
  } ctrl_t;

  // program rom: {ready, load, step, check, emit, cond, stay, target}
  function automatic ctrl_t ucode(input step_t pc);
    ctrl_t cw;
    cw = '{1'b0, 1'b0, 1'b0, 1'b0, EMIT_NONE, COND_ALWAYS, 1'b0, STEP_WAIT};
    case (pc)
      STEP_WAIT:  cw = '{1'b1, 1'b0, 1'b0, 1'b0, EMIT_NONE,  COND_ACCEPT,   1'b1, STEP_CHKIN};
      STEP_CHKIN: cw = '{1'b0, 1'b0, 1'b0, 1'b0, EMIT_NONE,  COND_BAD,      1'b0, STEP_ERR};
      STEP_TEST:  cw = '{1'b0, 1'b1, 1'b0, 1'b0, EMIT_NONE,  COND_SQ_GT,    1'b0, STEP_FIN};
      STEP_DIV:   cw = '{1'b0, 1'b0, 1'b1, 1'b0, EMIT_NONE,  COND_DIV_LAST, 1'b1, STEP_CHK};
      STEP_CHK:   cw = '{1'b0, 1'b0, 1'b0, 1'b1, EMIT_PAIR,  COND_ALWAYS,   1'b0, STEP_TEST};
      STEP_FIN:   cw = '{1'b0, 1'b0, 1'b0, 1'b0, EMIT_FINAL, COND_ALWAYS,   1'b0, STEP_WAIT};
      STEP_ERR:   cw = '{1'b0, 1'b0, 1'b0, 1'b0, EMIT_ERROR, COND_ALWAYS,   1'b0, STEP_WAIT};
      default:    cw = '{1'b0, 1'b0, 1'b0, 1'b0, EMIT_NONE,  COND_ALWAYS,   1'b0, STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage

### sv/pdp_ifs.sv
// ----------------------------------------------------------------------------
// pdp channel interfaces
// Valid/ready channels for the input number and the divisor-pair results.
// ----------------------------------------------------------------------------
interface pdp_in_if #(
  parameter int NUMBER_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [NUMBER_WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface pdp_out_if import pdp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SMALL_W-1:0] small_divisor;
  logic [LARGE_W-1:0] large_divisor;
  logic               pair_valid;
  logic               is_square_root;
  logic               input_error;
  logic               last_item;

  modport source (output valid, output small_divisor, output large_divisor,
                  output pair_valid, output is_square_root, output input_error,
                  output last_item, input ready);
  modport sink   (input valid, input small_divisor, input large_divisor,
                  input pair_valid, input is_square_root, input input_error,
                  input last_item, output ready);
endinterface

### sv/proper_divisor_pairs.sv
// Sequence: an error input passes the input check step and the error step before its item
// is loaded; otherwise each candidate takes one square test, NUMBER_WIDTH-1 divider steps
// and one check, and the final item is loaded once a candidate's square exceeds the number.
// Flow: one number at a time, taken only once the last item of the one before is loaded;
// the bit-serial restoring divider is shared by all candidates.
// Reset: synchronous active-low rst_n returns the sequencer to its wait step and empties
// the result register; nothing else is kept between numbers.
// ----------------------------------------------------------------------------
// proper_divisor_pairs
// Trial-division divisor pair lister driven by a small microcode program.
// ----------------------------------------------------------------------------
module proper_divisor_pairs import pdp_pkg::*; #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  pdp_in_if.sink     in_chan,
  pdp_out_if.source  out_chan
);

  localparam int DW = NUMBER_WIDTH - 1;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] DIV_LAST = CW'(DW - 1);

  // sequencer and datapath registers
  step_t               pc_r, pc_nxt;
  logic [NUMBER_WIDTH-1:0] num_r;
  logic [SMALL_W-1:0]  c_r;
  logic [SMALL_W-1:0]  rem_r;
  logic [DW-1:0]       qr_r;
  logic [CW-1:0]       cnt_r;

  // held pair, written out once the next one is found or the run ends
  logic                pend_v_r;
  logic [SMALL_W-1:0]  pend_c_r;
  logic [LARGE_W-1:0]  pend_q_r;
  logic                pend_sq_r;

  // result register
  logic                out_valid_r;
  logic [SMALL_W-1:0]  out_small_r;
  logic [LARGE_W-1:0]  out_large_r;
  logic                out_pair_r;
  logic                out_sq_r;
  logic                out_err_r;
  logic                out_last_r;

  ctrl_t               cw;
  logic                num_bad;
  logic                sq_gt;
  logic                rem_zero;
  logic [SMALL_W:0]    rem_sh;
  logic                rem_ge;
  logic                slot_free;
  logic                emit_req;
  logic                stall;
  logic                cond_true;
  logic [LARGE_W-1:0]  quot;

  // decode current step
  assign cw = ucode(pc_r);

  // status from the datapath
  assign num_bad   = num_r[NUMBER_WIDTH-1] || (num_r == '0);
  assign sq_gt     = (16'(c_r) * 16'(c_r)) > 16'(num_r[DW-1:0]);
  assign rem_zero  = (rem_r == '0);
  assign rem_sh    = {rem_r, qr_r[DW-1]};
  assign rem_ge    = rem_sh >= {1'b0, c_r};
  assign quot      = LARGE_W'(qr_r);

  // result slot handling
  assign slot_free = !out_valid_r || out_chan.ready;
  always_comb begin
    case (cw.emit)
      EMIT_PAIR:  emit_req = rem_zero && pend_v_r;
      EMIT_FINAL: emit_req = 1'b1;
      EMIT_ERROR: emit_req = 1'b1;
      default:    emit_req = 1'b0;
    endcase
  end
  assign stall = emit_req && !slot_free;

  // jump condition select
  always_comb begin
    case (cw.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_ACCEPT:   cond_true = in_chan.valid;
      COND_BAD:      cond_true = num_bad;
      COND_SQ_GT:    cond_true = sq_gt;
      COND_DIV_LAST: cond_true = (cnt_r == DIV_LAST);
      default:       cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = cw.target;
    end else if (cw.stay) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = step_t'(pc_r + 3'd1);
    end
  end

  assign in_chan.ready = cw.in_ready;

  // step counter and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= STEP_WAIT;
      pend_v_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (cw.in_ready && in_chan.valid) begin
        pend_v_r <= 1'b0;
      end else if (!stall && cw.check && rem_zero) begin
        pend_v_r <= 1'b1;
      end else if (!stall && cw.emit == EMIT_FINAL) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // number capture, candidate and divider
  always_ff @(posedge clk) begin
    if (cw.in_ready && in_chan.valid) begin
      num_r <= in_chan.number;
      c_r   <= FIRST_CAND;
    end
    if (cw.div_load) begin
      rem_r <= '0;
      qr_r  <= num_r[DW-1:0];
      cnt_r <= '0;
    end
    if (cw.div_step) begin
      rem_r <= rem_ge ? SMALL_W'(rem_sh - {1'b0, c_r}) : rem_sh[SMALL_W-1:0];
      qr_r  <= {qr_r[DW-2:0], rem_ge};
      cnt_r <= cnt_r + CW'(1);
    end
    if (cw.check && !stall) begin
      if (rem_zero) begin
        pend_c_r  <= c_r;
        pend_q_r  <= quot;
        pend_sq_r <= (quot == LARGE_W'(c_r));
      end
      c_r <= c_r + SMALL_W'(1);
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_req && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (emit_req && !stall) begin
      case (cw.emit)
        EMIT_PAIR: begin
          out_small_r <= pend_c_r;
          out_large_r <= pend_q_r;
          out_pair_r  <= 1'b1;
          out_sq_r    <= pend_sq_r;
          out_err_r   <= 1'b0;
          out_last_r  <= 1'b0;
        end
        EMIT_FINAL: begin
          out_small_r <= pend_v_r ? pend_c_r : '0;
          out_large_r <= pend_v_r ? pend_q_r : '0;
          out_pair_r  <= pend_v_r;
          out_sq_r    <= pend_v_r && pend_sq_r;
          out_err_r   <= 1'b0;
          out_last_r  <= 1'b1;
        end
        default: begin
          out_small_r <= '0;
          out_large_r <= '0;
          out_pair_r  <= 1'b0;
          out_sq_r    <= 1'b0;
          out_err_r   <= 1'b1;
          out_last_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.small_divisor  = out_small_r;
  assign out_chan.large_divisor  = out_large_r;
  assign out_chan.pair_valid     = out_pair_r;
  assign out_chan.is_square_root = out_sq_r;
  assign out_chan.input_error    = out_err_r;
  assign out_chan.last_item      = out_last_r;

`ifndef SYNTHESIS
  // an error item is always alone and carries no pair
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r && !out_pair_r)
    else $error("error item not final or carries a pair");

  // a reported pair never has a divisor below the first candidate
  a_pair_small: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pair_r |-> out_small_r >= FIRST_CAND)
    else $error("pair with small divisor below first candidate");

  // no held pair is left over once the sequencer waits for a number
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == STEP_WAIT |-> !pend_v_r)
    else $error("held pair survived end of run");

  // the result register only loads when its slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> $stable(out_small_r) && $stable(out_large_r))
    else $error("stalled result overwritten");
`endif

endmodule
